// ===== hw/rtl/dmf_pkg.sv =====
// Shared types and constants for the duplicate message filter.
package dmf_pkg;

  // Minimum datagram length that holds a full header.
  localparam int unsigned HeaderBytes = 64;

  // The magic "E852" as it arrives, with the first byte in bits 7:0.
  localparam logic [31:0] MagicWord = 32'h3235_3845;

  // Verdict codes reported with each result item.
  localparam logic [1:0] VerdictAccepted  = 2'd0;
  localparam logic [1:0] VerdictDuplicate = 2'd1;
  localparam logic [1:0] VerdictMalformed = 2'd2;

  // One history entry: the identifying triple of a message.
  typedef struct packed {
    logic [31:0] process;
    logic [31:0] host;
    logic [31:0] sequence_nr;
  } triple_t;

  localparam int unsigned TripleBits = $bits(triple_t);

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

endpackage

// ===== hw/rtl/dmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dmf_ram
  import dmf_pkg::*;
#(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 20
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/duplicate_message_filter_top.sv =====
// Top level of the duplicate message filter: header check, history scan and update.
//
//   channel   direction  handshake                 payload
//   input     in         start && !busy            in_message_length, in_magic_bytes,
//                                                  in_sender_process, in_sender_host,
//                                                  in_sequence_number
//   result    out        out_valid, one cycle      out_verdict, out_accepted_length
//
// A malformed item gives its result in the cycle after it is accepted and leaves busy low.
// A well-formed item scans the history one entry a cycle through the single read port
// of the history RAM, so its result comes after the last entry is compared, earlier
// when a duplicate is found. Busy drops as the result is shown, so the next item can be
// taken in the cycle its result is shown.
// Reset clears the valid bits and the replace pointer at once; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module duplicate_message_filter_top
  import dmf_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_message_length,
  input  logic [31:0] in_magic_bytes,
  input  logic [31:0] in_sender_process,
  input  logic [31:0] in_sender_host,
  input  logic [31:0] in_sequence_number,
  output logic        out_valid,
  output logic [1:0]  out_verdict,
  output logic [15:0] out_accepted_length
);

  localparam int unsigned PtrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(HISTORY_DEPTH - 1);

  state_t                  state_r, state_nxt;
  triple_t                 key_r, key_nxt;
  logic [15:0]             len_r, len_nxt;
  logic [HISTORY_DEPTH-1:0] valid_r, valid_nxt;
  logic [PtrW-1:0]         ptr_r, ptr_nxt;
  logic [PtrW-1:0]         issue_idx_r, issue_idx_nxt;
  logic                    issuing_r, issuing_nxt;
  logic [PtrW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic                    cmp_last_r, cmp_last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_verdict_r, out_verdict_nxt;
  logic [15:0]             out_len_r, out_len_nxt;

  logic                    accept;
  logic                    malformed;
  logic                    hit;
  logic                    ram_wr_en;
  triple_t                 ram_rd_data;
  triple_t                 in_key;

  assign accept    = start && (state_r == S_IDLE);
  assign malformed = (in_message_length < 16'(HeaderBytes)) || (in_magic_bytes != MagicWord);
  assign in_key    = '{process: in_sender_process, host: in_sender_host,
                       sequence_nr: in_sequence_number};

  // An entry matches only if it holds a valid triple equal to the key.
  assign hit = cmp_vld_r && valid_r[cmp_idx_r] && (ram_rd_data == key_r);

  // History store; written only when a new item is taken into the history.
  dmf_ram #(
    .WIDTH (TripleBits),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ptr_r),
    .wr_data (key_r),
    .rd_en   (issuing_r),
    .rd_addr (issue_idx_r),
    .rd_data (ram_rd_data)
  );

  // Controller: accept, scan the history in order, then report and update.
  always_comb begin
    state_nxt       = state_r;
    key_nxt         = key_r;
    len_nxt         = len_r;
    valid_nxt       = valid_r;
    ptr_nxt         = ptr_r;
    issue_idx_nxt   = issue_idx_r;
    issuing_nxt     = issuing_r;
    cmp_idx_nxt     = cmp_idx_r;
    cmp_vld_nxt     = 1'b0;
    cmp_last_nxt    = cmp_last_r;
    out_valid_nxt   = 1'b0;
    out_verdict_nxt = out_verdict_r;
    out_len_nxt     = out_len_r;
    ram_wr_en       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (malformed) begin
            out_valid_nxt   = 1'b1;
            out_verdict_nxt = VerdictMalformed;
            out_len_nxt     = '0;
          end else begin
            key_nxt       = in_key;
            len_nxt       = in_message_length;
            issue_idx_nxt = '0;
            issuing_nxt   = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous entry is compared.
        cmp_vld_nxt  = issuing_r;
        cmp_idx_nxt  = issue_idx_r;
        cmp_last_nxt = (issue_idx_r == LastIdx);
        if (issuing_r) begin
          if (issue_idx_r == LastIdx) begin
            issuing_nxt = 1'b0;
          end else begin
            issue_idx_nxt = issue_idx_r + 1'b1;
          end
        end

        if (hit) begin
          out_valid_nxt   = 1'b1;
          out_verdict_nxt = VerdictDuplicate;
          out_len_nxt     = '0;
          issuing_nxt     = 1'b0;
          cmp_vld_nxt     = 1'b0;
          state_nxt       = S_IDLE;
        end else if (cmp_vld_r && cmp_last_r) begin
          // No match anywhere: take the item into the oldest slot.
          ram_wr_en          = 1'b1;
          valid_nxt[ptr_r]   = 1'b1;
          ptr_nxt            = (ptr_r == LastIdx) ? '0 : ptr_r + 1'b1;
          out_valid_nxt      = 1'b1;
          out_verdict_nxt    = VerdictAccepted;
          out_len_nxt        = len_r;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt   = S_IDLE;
        issuing_nxt = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      ptr_r       <= '0;
      issuing_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      ptr_r       <= ptr_nxt;
      issuing_r   <= issuing_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan index registers.
  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    len_r         <= len_nxt;
    issue_idx_r   <= issue_idx_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    cmp_last_r    <= cmp_last_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_len_r     <= out_len_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_verdict         = out_verdict_r;
  assign out_accepted_length = out_len_r;

endmodule

// ===== verif/duplicate_message_filter_top_tb.sv =====
// Self-checking testbench for the duplicate message filter top level.
`timescale 1ns / 100ps

module duplicate_message_filter_top_tb;
  import dmf_pkg::*;

  localparam int unsigned HISTORY_DEPTH = 20;
  localparam int unsigned RANDOM_MSGS = 450;
  localparam int unsigned RECENT_KEEP = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One received message header as presented on the input ports.
  typedef struct {
    logic [15:0] length;
    logic [31:0] magic;
    triple_t     id;
  } msg_t;

  // What the filter reports for one message.
  typedef struct {
    logic [1:0]  verdict;
    logic [15:0] length;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_message_length = '0;
  logic [31:0] in_magic_bytes = '0;
  logic [31:0] in_sender_process = '0;
  logic [31:0] in_sender_host = '0;
  logic [31:0] in_sequence_number = '0;
  logic        out_valid;
  logic [1:0]  out_verdict;
  logic [15:0] out_accepted_length;

  // Messages waiting to be sent and verdicts waiting to come back.
  msg_t     pending_msgs[$];
  outcome_t expected_outcomes[$];
  triple_t  recent_ids[$];

  // Private copy of the message history.
  triple_t                  seen_ids[HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] seen_valid = '0;
  int unsigned              replace_slot = 0;

  int unsigned n_accepted = 0;
  int unsigned n_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  duplicate_message_filter_top #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_message_length  (in_message_length),
    .in_magic_bytes     (in_magic_bytes),
    .in_sender_process  (in_sender_process),
    .in_sender_host     (in_sender_host),
    .in_sequence_number (in_sequence_number),
    .out_valid          (out_valid),
    .out_verdict        (out_verdict),
    .out_accepted_length(out_accepted_length)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Screen one message against the history and record it when it is new.
  function automatic outcome_t screen_message(msg_t m);
    outcome_t    res;
    logic        hit;
    int unsigned slot;
    res.verdict = VerdictMalformed;
    res.length = '0;
    if (m.length < HeaderBytes || m.magic != MagicWord) begin
      return res;
    end
    hit = 1'b0;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (seen_valid[k] && seen_ids[k] == m.id) begin
        hit = 1'b1;
      end
    end
    if (hit) begin
      res.verdict = VerdictDuplicate;
      return res;
    end
    slot = (replace_slot < HISTORY_DEPTH) ? replace_slot : 0;
    seen_ids[slot] = m.id;
    seen_valid[slot] = 1'b1;
    replace_slot = (slot + 1 >= HISTORY_DEPTH) ? 0 : slot + 1;
    res.verdict = VerdictAccepted;
    res.length = m.length;
    return res;
  endfunction

  task automatic queue_msg(input logic [15:0] length, input logic [31:0] magic,
                           input logic [31:0] process, input logic [31:0] host,
                           input logic [31:0] seq);
    msg_t m;
    m.length = length;
    m.magic = magic;
    m.id.process = process;
    m.id.host = host;
    m.id.sequence_nr = seq;
    pending_msgs.push_back(m);
  endtask

  // Pick one identifier field, sometimes an extreme value.
  function automatic logic [31:0] pick_field();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return $urandom();
  endfunction

  // Sender: raise start with the next item, hold it until it is taken.
  always @(negedge clk) begin
    msg_t nxt;
    logic go;
    logic quiet;
    if (rst_n) begin
      go = start;
      if (start && n_accepted != n_taken) begin
        n_taken++;
        go = 1'b0;
      end
      quiet = (n_taken >= 200 && n_taken < 300);
      if (!go && pending_msgs.size() > 0 && (quiet || $urandom_range(99) >= 37)) begin
        nxt = pending_msgs.pop_front();
        go = 1'b1;
        in_message_length <= nxt.length;
        in_magic_bytes <= nxt.magic;
        in_sender_process <= nxt.id.process;
        in_sender_host <= nxt.id.host;
        in_sequence_number <= nxt.id.sequence_nr;
      end
      start <= go;
    end
  end

  // Result checker and acceptance tracker, both sampled at the rising edge.
  always @(posedge clk) begin
    outcome_t want;
    msg_t     arrived;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result, verdict %0d length %0d", $time,
                   out_verdict, out_accepted_length);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          if (out_verdict !== want.verdict) begin
            $display("%0t: verdict mismatch, expected %0d actual %0d", $time,
                     want.verdict, out_verdict);
            mismatches++;
          end
          if (out_accepted_length !== want.length) begin
            $display("%0t: accepted length mismatch, expected %0d actual %0d", $time,
                     want.length, out_accepted_length);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        arrived.length = in_message_length;
        arrived.magic = in_magic_bytes;
        arrived.id.process = in_sender_process;
        arrived.id.host = in_sender_host;
        arrived.id.sequence_nr = in_sequence_number;
        expected_outcomes.push_back(screen_message(arrived));
        n_accepted++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    triple_t     id;
    logic [15:0] length;
    logic [31:0] magic;

    // Directed: the all-zero triple, length limits, magic errors, near misses.
    queue_msg(16'd64, MagicWord, '0, '0, '0);
    queue_msg(16'd64, MagicWord, '0, '0, '0);
    queue_msg(16'd63, MagicWord, 32'd1, 32'd2, 32'd3);
    queue_msg(16'd0, '0, '0, '0, '0);
    queue_msg(16'd0, MagicWord, 32'd7, 32'd7, 32'd7);
    queue_msg(16'd10, MagicWord, '0, '0, '0);
    queue_msg(16'd65535, MagicWord, '1, '1, '1);
    queue_msg(16'd65535, '1, 32'd4, 32'd5, 32'd6);
    queue_msg(16'd64, MagicWord ^ 32'h0000_0001, 32'd8, 32'd9, 32'd10);
    queue_msg(16'd64, MagicWord ^ 32'h8000_0000, 32'd8, 32'd9, 32'd10);
    queue_msg(16'd64, 32'h4538_3532, 32'd8, 32'd9, 32'd10);
    queue_msg(16'd63, 32'h1234_5678, '1, '1, '1);
    queue_msg(16'd100, MagicWord, '1, '1, '0);
    queue_msg(16'd101, MagicWord, '1, '0, '1);
    queue_msg(16'd102, MagicWord, '0, '1, '1);
    queue_msg(16'd200, MagicWord, '1, '1, '1);
    queue_msg(16'd1024, MagicWord, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_msg(16'd1024, MagicWord, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_msg(16'd65, MagicWord, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_msg(16'd64, MagicWord, '0, '0, '0);

    // Random: mostly well-formed messages, with repeats drawn from recent ones so that
    // both live duplicates and entries already pushed out of the history come back.
    for (int n = 0; n < RANDOM_MSGS; n++) begin
      r = $urandom_range(99);
      if (r < 35 && recent_ids.size() > 0) begin
        id = recent_ids[$urandom_range(recent_ids.size() - 1)];
      end else begin
        id.process = pick_field();
        id.host = pick_field();
        id.sequence_nr = pick_field();
      end
      length = ($urandom_range(3) == 0) ? 16'(HeaderBytes) : 16'($urandom_range(64, 65535));
      magic = MagicWord;
      if (r >= 88) begin
        case ($urandom_range(2))
          0: length = 16'($urandom_range(HeaderBytes - 1));
          1: magic = MagicWord ^ (32'h1 << $urandom_range(31));
          default: magic = $urandom();
        endcase
      end else begin
        recent_ids.push_front(id);
        if (recent_ids.size() > RECENT_KEEP) begin
          void'(recent_ids.pop_back());
        end
      end
      queue_msg(length, magic, id.process, id.host, id.sequence_nr);
    end

    // Reset is released on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: everything sent, everything answered, then a short settling time.
    while (pending_msgs.size() != 0 || start || expected_outcomes.size() != 0) begin
      @(posedge clk);
    end
    repeat (HISTORY_DEPTH + 4) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
